### design/mtfb_pkg.sv
// ----------------------------------------------------------------------------
// mtfb_pkg: shared constants and types for the mesh transform / face bounds core
// Field widths, result kind codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mtfb_pkg;

  localparam int POS_W   = 32;   // input position field width
  localparam int NRM_W   = 16;   // input normal field width
  localparam int OUT_W   = 32;   // result value field width
  localparam int EXT_W   = 31;   // result size field width
  localparam int NSUM_W  = 18;   // normal sum width
  localparam int ROW_W   = 48;   // packed coefficient row width
  localparam int OFF_W   = 32;   // translation register width
  localparam int CFG_AW  = 6;
  localparam int CFG_DW  = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_COEF_WIDTH  = 16;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_POINT  = 2'd0;
  localparam kind_t KIND_NORMAL = 2'd1;
  localparam kind_t KIND_FACE   = 2'd2;
  localparam kind_t KIND_MESH   = 2'd3;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_ROW_X = 3'd0;
  localparam reg_idx_t REG_ROW_Y = 3'd1;
  localparam reg_idx_t REG_ROW_Z = 3'd2;
  localparam reg_idx_t REG_OFF_X = 3'd3;
  localparam reg_idx_t REG_OFF_Y = 3'd4;
  localparam reg_idx_t REG_OFF_Z = 3'd5;

  localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h4000_0000_0000;

endpackage

`default_nettype wire

### design/mtfb_fifo.sv
// ----------------------------------------------------------------------------
// mtfb_fifo: small vertex queue
// Register-based FIFO between the transform front and the face back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfb_fifo #(
  parameter int WIDTH = 145,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### design/mtfb_front.sv
// ----------------------------------------------------------------------------
// mtfb_front: vertex intake and transform
// One shared multiplier runs the 3x3 product, rounds, offsets and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfb_front #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16,
  parameter int VW = 3 * COORD_WIDTH + 3 * 16 + 1
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [3*mtfb_pkg::POS_W-1:0]            in_pos,
  input  wire logic [3*mtfb_pkg::NRM_W-1:0]            in_nrm,
  input  wire logic                                    in_last,
  input  wire logic [2:0][mtfb_pkg::ROW_W-1:0]         rows,
  input  wire logic [2:0][mtfb_pkg::OFF_W-1:0]         offs,
  output logic                                         q_valid,
  input  wire logic                                    q_ready,
  output logic [VW-1:0]                                q_data
);
  import mtfb_pkg::*;

  localparam int F    = COEF_WIDTH - 2;
  localparam int PW   = POS_W + COEF_WIDTH;
  localparam int ACCW = PW + 2;
  localparam int SHW  = ACCW - F;
  localparam int SW   = ((COORD_WIDTH > SHW) ? COORD_WIDTH : SHW) + 2;
  localparam int XW   = 3 * COEF_WIDTH + ROW_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [1:0] row_r, row_nxt, sub_r, sub_nxt;
  logic signed [POS_W-1:0]       pos_r [3];
  logic [3*NRM_W-1:0]            nrm_r;
  logic                          last_r;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic signed [ACCW-1:0]        acc_r, acc_nxt;
  logic signed [COORD_WIDTH-1:0] pt_r [3];

  logic [XW-1:0]                 row_ext;
  logic signed [COEF_WIDTH-1:0]  coef;
  logic signed [POS_W-1:0]       pos_sel;
  logic [1:0]                    j;
  logic signed [ACCW-1:0]        sum, rnd;
  logic signed [SHW-1:0]         shr;
  logic signed [SW-1:0]          tot, hi, lo;
  logic signed [COORD_WIDTH-1:0] sat;

  assign in_ready = (st_r == S_IDLE);
  assign q_valid  = (st_r == S_PUSH);
  assign q_data   = {last_r, nrm_r, pt_r[2], pt_r[1], pt_r[0]};

  always_comb begin
    j       = (sub_r == 2'd3) ? 2'd0 : sub_r;
    row_ext = {{(3 * COEF_WIDTH){1'b0}}, rows[row_r]};
    coef    = row_ext[j * COEF_WIDTH +: COEF_WIDTH];
    pos_sel = pos_r[j];
    prod_nxt = PW'(pos_sel) * PW'(coef);
    acc_nxt  = (sub_r == 2'd0) ? '0 : acc_r + ACCW'(prod_r);
    sum = acc_r + ACCW'(prod_r);
    rnd = sum + (ACCW'(1) << (F - 1));
    shr = SHW'(rnd >>> F);
    tot = SW'(shr) + SW'($signed(offs[row_r]));
    hi  = {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    lo  = ~hi;
    if (tot > hi) begin
      sat = COORD_WIDTH'(hi);
    end else if (tot < lo) begin
      sat = COORD_WIDTH'(lo);
    end else begin
      sat = COORD_WIDTH'(tot);
    end
  end

  always_comb begin
    st_nxt  = st_r;
    row_nxt = row_r;
    sub_nxt = sub_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt  = S_MUL;
          row_nxt = 2'd0;
          sub_nxt = 2'd0;
        end
      end
      S_MUL: begin
        sub_nxt = sub_r + 2'd1;
        if (sub_r == 2'd3) begin
          row_nxt = row_r + 2'd1;
          if (row_r == 2'd2) begin
            st_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (q_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      row_r <= '0;
      sub_r <= '0;
    end else begin
      st_r  <= st_nxt;
      row_r <= row_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid) begin
      pos_r[0] <= in_pos[0 +: POS_W];
      pos_r[1] <= in_pos[POS_W +: POS_W];
      pos_r[2] <= in_pos[2 * POS_W +: POS_W];
      nrm_r    <= in_nrm;
      last_r   <= in_last;
    end
    if (st_r == S_MUL) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
      if (sub_r == 2'd3) begin
        pt_r[row_r] <= sat;
      end
    end
  end

endmodule

`default_nettype wire

### design/mtfb_back.sv
// ----------------------------------------------------------------------------
// mtfb_back: face and mesh bookkeeping
// Tracks face/mesh boxes, normalizes the face normal with an iterative
// square root and divider, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfb_back #(
  parameter int COORD_WIDTH = 32,
  parameter int VW = 3 * COORD_WIDTH + 3 * 16 + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire logic [VW-1:0]             q_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output mtfb_pkg::kind_t                out_kind,
  output logic [3*mtfb_pkg::OUT_W-1:0]   out_val,
  output logic [3*mtfb_pkg::EXT_W-1:0]   out_ext,
  output logic                           out_last
);
  import mtfb_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = ((CW + 1) > 33) ? (CW + 1) : 33;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_PT    = 4'd1;
  localparam logic [3:0] B_SQ    = 4'd2;
  localparam logic [3:0] B_SQRT  = 4'd3;
  localparam logic [3:0] B_DINIT = 4'd4;
  localparam logic [3:0] B_DIV   = 4'd5;
  localparam logic [3:0] B_NRM   = 4'd6;
  localparam logic [3:0] B_BOX   = 4'd7;
  localparam logic [3:0] B_MESH  = 4'd8;

  logic [3:0] st_r, st_nxt;

  logic signed [CW-1:0]     vpt_r [3];
  logic signed [NRM_W-1:0]  vnrm_r [3];
  logic                     vlast_r;

  logic [1:0]               cc_r;
  logic                     mhas_r;
  logic signed [CW-1:0]     fmin_r [3], fmax_r [3], mmin_r [3], mmax_r [3];
  logic signed [NSUM_W-1:0] nsum_r [3];

  logic [1:0]               idx_r;
  logic [34:0]              sq_r;
  logic [36:0]              qacc_r;
  logic [63:0]              x_r, r_r, bit_r;
  logic [47:0]              rem_r, d_r;
  logic [3:0]               k_r;
  logic [15:0]              quo_r;
  logic signed [16:0]       nres_r [3];

  logic                     ovld_r;
  kind_t                    kind_r;
  logic [3*OUT_W-1:0]       val_r;
  logic [3*EXT_W-1:0]       ext_r;
  logic                     olast_r;

  logic                     ld, complete, ofire;
  logic signed [2*NSUM_W-1:0] sqp;
  logic [63:0]              rb;
  logic                     sq_ge;
  logic [31:0]              len;
  logic [NSUM_W-1:0]        sabs;
  logic                     d_ge;
  logic [15:0]              quo_nxt;
  logic [3*EXT_W-1:0]       fsz, msz;
  logic [3*OUT_W-1:0]       ptv, fminv, mminv, nrmv;

  function automatic logic [EXT_W-1:0] bsize(input logic signed [CW-1:0] mn,
                                             input logic signed [CW-1:0] mx);
    logic signed [DW-1:0] d;
    d = DW'(mx) - DW'(mn);
    if (d > DW'(32'h7FFF_FFFF)) begin
      return {EXT_W{1'b1}};
    end
    return d[EXT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] to32(input logic signed [CW-1:0] v);
    logic signed [CW+OUT_W-1:0] e;
    e = (CW + OUT_W)'(v);
    return e[OUT_W-1:0];
  endfunction

  assign q_ready   = (st_r == B_IDLE);
  assign out_valid = ovld_r;
  assign out_kind  = kind_r;
  assign out_val   = val_r;
  assign out_ext   = ext_r;
  assign out_last  = olast_r;
  assign ld        = !ovld_r || out_ready;
  assign complete  = (cc_r == 2'd2);
  assign len       = r_r[31:0];
  assign ofire     = ld && (st_r == B_PT || st_r == B_NRM || st_r == B_BOX ||
                            st_r == B_MESH);

  always_comb begin
    sqp   = nsum_r[idx_r] * nsum_r[idx_r];
    rb    = r_r + bit_r;
    sq_ge = (x_r >= rb);
    sabs  = nsum_r[idx_r][NSUM_W-1] ? NSUM_W'(-nsum_r[idx_r]) : nsum_r[idx_r];
    d_ge  = (rem_r >= d_r);
    quo_nxt = quo_r;
    quo_nxt[k_r] = d_ge;
    for (int i = 0; i < 3; i++) begin
      fsz[i*EXT_W +: EXT_W]   = bsize(fmin_r[i], fmax_r[i]);
      msz[i*EXT_W +: EXT_W]   = mhas_r ? bsize(mmin_r[i], mmax_r[i]) : '0;
      ptv[i*OUT_W +: OUT_W]   = to32(vpt_r[i]);
      fminv[i*OUT_W +: OUT_W] = to32(fmin_r[i]);
      mminv[i*OUT_W +: OUT_W] = mhas_r ? to32(mmin_r[i]) : '0;
      nrmv[i*OUT_W +: OUT_W]  = OUT_W'(nres_r[i]);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:  if (q_valid) st_nxt = B_PT;
      B_PT: begin
        if (ld) begin
          if (complete) begin
            st_nxt = B_SQ;
          end else if (vlast_r) begin
            st_nxt = B_MESH;
          end else begin
            st_nxt = B_IDLE;
          end
        end
      end
      B_SQ:    if (idx_r == 2'd3) st_nxt = B_SQRT;
      B_SQRT:  if (bit_r[0]) st_nxt = B_DINIT;
      B_DINIT: if (len == '0 && idx_r == 2'd2) st_nxt = B_NRM;
               else if (len != '0) st_nxt = B_DIV;
      B_DIV: begin
        if (k_r == 4'd0) begin
          st_nxt = (idx_r == 2'd2) ? B_NRM : B_DINIT;
        end
      end
      B_NRM:   if (ld) st_nxt = B_BOX;
      B_BOX:   if (ld) st_nxt = vlast_r ? B_MESH : B_IDLE;
      B_MESH:  if (ld) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      ovld_r <= 1'b0;
      cc_r   <= '0;
      mhas_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        fmin_r[i] <= '0;
        fmax_r[i] <= '0;
        nsum_r[i] <= '0;
        mmin_r[i] <= '0;
        mmax_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (ofire) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
      case (st_r)
        B_PT: begin
          if (ld) begin
            cc_r   <= complete ? 2'd0 : cc_r + 2'd1;
            for (int i = 0; i < 3; i++) begin
              if (cc_r == 2'd0) begin
                fmin_r[i] <= vpt_r[i];
                fmax_r[i] <= vpt_r[i];
                nsum_r[i] <= NSUM_W'(vnrm_r[i]);
              end else begin
                if (vpt_r[i] < fmin_r[i]) fmin_r[i] <= vpt_r[i];
                if (vpt_r[i] > fmax_r[i]) fmax_r[i] <= vpt_r[i];
                nsum_r[i] <= nsum_r[i] + NSUM_W'(vnrm_r[i]);
              end
            end
          end
        end
        B_BOX: begin
          if (ld) begin
            mhas_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              if (!mhas_r || fmin_r[i] < mmin_r[i]) mmin_r[i] <= fmin_r[i];
              if (!mhas_r || fmax_r[i] > mmax_r[i]) mmax_r[i] <= fmax_r[i];
            end
          end
        end
        B_MESH: begin
          if (ld) begin
            cc_r   <= '0;
            mhas_r <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              mmin_r[i] <= '0;
              mmax_r[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          for (int i = 0; i < 3; i++) begin
            vpt_r[i]  <= q_data[i*CW +: CW];
            vnrm_r[i] <= q_data[3*CW + i*NRM_W +: NRM_W];
          end
          vlast_r <= q_data[VW-1];
        end
      end
      B_PT: begin
        if (ld) begin
          kind_r  <= KIND_POINT;
          val_r   <= ptv;
          ext_r   <= '0;
          olast_r <= !complete && !vlast_r;
          idx_r   <= 2'd0;
        end
      end
      B_SQ: begin
        sq_r   <= sqp[34:0];
        qacc_r <= (idx_r == 2'd0) ? '0 : qacc_r + 37'(sq_r);
        if (idx_r == 2'd3) begin
          x_r   <= {qacc_r[35:0] + 36'(sq_r), 28'd0};
          r_r   <= '0;
          bit_r <= 64'd1 << 62;
          idx_r <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      B_SQRT: begin
        if (sq_ge) begin
          x_r <= x_r - rb;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      B_DINIT: begin
        if (len == '0) begin
          nres_r[idx_r] <= '0;
          idx_r <= idx_r + 2'd1;
        end else begin
          rem_r <= 48'({sabs[16:0], 28'd0}) + 48'(len >> 1);
          d_r   <= 48'(len) << 15;
          k_r   <= 4'd15;
          quo_r <= '0;
        end
      end
      B_DIV: begin
        if (d_ge) rem_r <= rem_r - d_r;
        d_r   <= d_r >> 1;
        k_r   <= k_r - 4'd1;
        quo_r <= quo_nxt;
        if (k_r == 4'd0) begin
          nres_r[idx_r] <= nsum_r[idx_r][NSUM_W-1] ? -$signed({1'b0, quo_nxt})
                                                   : $signed({1'b0, quo_nxt});
          idx_r <= idx_r + 2'd1;
        end
      end
      B_NRM: begin
        if (ld) begin
          kind_r  <= KIND_NORMAL;
          val_r   <= nrmv;
          ext_r   <= '0;
          olast_r <= 1'b0;
        end
      end
      B_BOX: begin
        if (ld) begin
          kind_r  <= KIND_FACE;
          val_r   <= fminv;
          ext_r   <= fsz;
          olast_r <= !vlast_r;
        end
      end
      B_MESH: begin
        if (ld) begin
          kind_r  <= KIND_MESH;
          val_r   <= mminv;
          ext_r   <= msz;
          olast_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/mesh_transform_face_bounds_core.sv
// ----------------------------------------------------------------------------
// mesh_transform_face_bounds_core: vertex transform with face and mesh bounds
// Transforms vertices, emits per-face unit normal and box, and the mesh box.
// ----------------------------------------------------------------------------
// Each accepted vertex gives a transformed point (kind 0). Every third vertex
// also gives the face's unit normal (kind 1) and the face box (kind 2, min
// corner plus size); a vertex with tlast set closes the mesh with the union
// box (kind 3) and drops any partial face. out_tlast marks the last result of
// each vertex. Positions are Q16.16, coefficients Q1.14, with saturation.
// The front end takes a new vertex only when idle: it runs the 3x3 product on
// the single shared multiplier, then pushes the point into the queue, stalling
// there while the queue is full. The back end pops each point and issues its
// result, stalling while the sink holds off; per completed face it then squares
// the normal sums, takes the bit-pair square root and runs the 16-bit restoring
// divider once per component, then issues the normal and face box results.
// A two-entry queue lets the front keep transforming while the back end
// normalizes.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_transform_face_bounds_core #(
  parameter int COORD_WIDTH = mtfb_pkg::DEF_COORD_WIDTH,
  parameter int COEF_WIDTH  = mtfb_pkg::DEF_COEF_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (low bit up)
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [143:0]                  in_tdata,
  input  wire logic                          in_tlast,   // last_vertex
  // out_tdata: val_x, val_y, val_z, ext_x, ext_y, ext_z, 3 zero pad bits
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [191:0]                       out_tdata,
  output logic [1:0]                         out_tuser,  // kind
  output logic                               out_tlast,  // last_of_run
  // register port
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [mtfb_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [mtfb_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [mtfb_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);
  import mtfb_pkg::*;

  localparam int VW = 3 * COORD_WIDTH + 3 * NRM_W + 1;

  logic [2:0][ROW_W-1:0] rows_r;
  logic [2:0][OFF_W-1:0] offs_r;
  logic                  wr_en;
  reg_idx_t              ridx;

  logic                  q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  logic [VW-1:0]         q_in_data, q_out_data;
  kind_t                 kind;
  logic [3*OUT_W-1:0]    val;
  logic [3*EXT_W-1:0]    ext;

  // registers sit at 8-byte strides since the coefficient rows are 48 bits
  assign ridx       = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (ridx)
      REG_ROW_X: cfg_prdata = CFG_DW'(rows_r[0]);
      REG_ROW_Y: cfg_prdata = CFG_DW'(rows_r[1]);
      REG_ROW_Z: cfg_prdata = CFG_DW'(rows_r[2]);
      REG_OFF_X: cfg_prdata = CFG_DW'(offs_r[0]);
      REG_OFF_Y: cfg_prdata = CFG_DW'(offs_r[1]);
      REG_OFF_Z: cfg_prdata = CFG_DW'(offs_r[2]);
      default:   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= ROW_X_RST;
      rows_r[1] <= ROW_Y_RST;
      rows_r[2] <= ROW_Z_RST;
      offs_r    <= '0;
    end else if (wr_en) begin
      case (ridx)
        REG_ROW_X: rows_r[0] <= cfg_pwdata[ROW_W-1:0];
        REG_ROW_Y: rows_r[1] <= cfg_pwdata[ROW_W-1:0];
        REG_ROW_Z: rows_r[2] <= cfg_pwdata[ROW_W-1:0];
        REG_OFF_X: offs_r[0] <= cfg_pwdata[OFF_W-1:0];
        REG_OFF_Y: offs_r[1] <= cfg_pwdata[OFF_W-1:0];
        REG_OFF_Z: offs_r[2] <= cfg_pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // front: intake and transform
  mtfb_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .VW          (VW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pos   (in_tdata[95:0]),
    .in_nrm   (in_tdata[143:96]),
    .in_last  (in_tlast),
    .rows     (rows_r),
    .offs     (offs_r),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  // queue decouples transform from normalization
  mtfb_fifo #(
    .WIDTH (VW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  // back: face/mesh state, normal, result register
  mtfb_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .VW          (VW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_data    (q_out_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind),
    .out_val   (val),
    .out_ext   (ext),
    .out_last  (out_tlast)
  );

  assign out_tuser = kind;
  assign out_tdata = {3'b000, ext, val};

endmodule

`default_nettype wire

### design/mtfb_checker.sv
// ----------------------------------------------------------------------------
// mtfb_checker: port-level checks for the mesh transform core
// Watches result hold, size and last-marker rules visible on the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfb_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [191:0] out_tdata,
  input wire logic [1:0]   out_tuser,
  input wire logic         out_tlast
);
  import mtfb_pkg::*;

  // a result waiting on the sink keeps its kind
  a_kind_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tuser))
    else $error("result kind changed while stalled");

  // points and normals carry no size
  a_no_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_POINT || out_tuser == KIND_NORMAL)
      |-> out_tdata[188:96] == '0)
    else $error("size nonzero on point or normal");

  // mesh box always closes the run of its vertex
  a_mesh_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_MESH |-> out_tlast)
    else $error("mesh box without last marker");

  // the normal is never the final result of a vertex
  a_nrm_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_NORMAL |-> !out_tlast)
    else $error("face normal marked last");

endmodule

bind mesh_transform_face_bounds_core mtfb_checker u_mtfb_checker (.*);

`default_nettype wire
